[design/tga_rle_pixel_encoder_assert.svh]
// assertion helpers shared by the encoder modules
// every macro samples on clk and is quiet while arst_n is low
`ifndef TGA_RLE_PIXEL_ENCODER_ASSERT_SVH
`define TGA_RLE_PIXEL_ENCODER_ASSERT_SVH

// condition holds at every edge
`define TRLE_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define TRLE_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the trigger
`define TRLE_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/trle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package trle_pkg;

	localparam int MAX_PACKET  = 128;
	localparam int OFFSET_BITS = 34;
	localparam int LEN_BITS    = $clog2(MAX_PACKET + 1);

	localparam int PIX_BITS  = 24;
	localparam int OFF_FIELD = 34;
	localparam int DIM_BITS  = 16;

	localparam logic [7:0]  RUN_FLAG    = 8'h80;
	localparam logic [7:0]  PAD_BYTE    = 8'hff;
	localparam logic [15:0] RGB_HI_MASK = 16'hffc0;
	localparam logic [15:0] RGB_LO_MASK = 16'h001f;

	// register indexes on the config channel
	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_ROWS  = 2'd2;

	typedef enum logic [1:0] {
		MODE_MONO  = 2'd0,
		MODE_INDEX = 2'd1,
		MODE_RGB16 = 2'd2,
		MODE_RGB24 = 2'd3
	} depth_t;

	typedef struct packed {
		depth_t                depth_mode;
		logic [DIM_BITS-1:0]   image_width;
		logic [DIM_BITS-1:0]   image_rows;
		logic                  clear;
	} cfg_t;

	// slots of one op list, walked in this order
	localparam int NSLOT     = 7;
	localparam int SLOT_BITS = $clog2(NSLOT);
	localparam int SL_M1 = 0;
	localparam int SL_M2 = 1;
	localparam int SL_M3 = 2;
	localparam int SL_L1 = 3;
	localparam int SL_L2 = 4;
	localparam int SL_P1 = 5;
	localparam int SL_P2 = 6;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,	// one byte at the running offset
		OP_PIXEL = 2'd1,	// formatted pixel bytes at the running offset
		OP_HDR   = 2'd2	// raw header byte at the reserved offset
	} op_t;

	typedef struct packed {
		logic                en;
		op_t                 kind;
		logic                opn;	// pixel opens a raw packet, reserve header first
		logic [PIX_BITS-1:0] data;
	} slot_t;

	typedef struct packed {
		slot_t [NSLOT-1:0] slot;
		logic              img_end;
	} oplist_t;

endpackage

`default_nettype wire

[design/trle_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module trle_cfg import trle_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [DIM_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	depth_t              depth_q;
	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] rows_q;
	logic                wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= MODE_INDEX;
			width_q <= DIM_BITS'(1);
			rows_q  <= DIM_BITS'(1);
		end else if (wr) begin
			case (cfg_index)
				REG_DEPTH: depth_q <= depth_t'(cfg_data[1:0]);
				REG_WIDTH: width_q <= cfg_data;
				REG_ROWS:  rows_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// a write to a known register restarts the stream at the same edge
	always_comb begin
		cfg.depth_mode  = depth_q;
		cfg.image_width = width_q;
		cfg.image_rows  = rows_q;
		case (cfg_index)
			REG_DEPTH, REG_WIDTH, REG_ROWS: cfg.clear = wr;
			default:                        cfg.clear = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

[design/trle_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module trle_core import trle_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [PIX_BITS-1:0] s_tdata,
	output logic                     list_valid,
	output oplist_t                  list,
	input  wire logic                list_take
);

	`include "tga_rle_pixel_encoder_assert.svh"

	logic [PIX_BITS-1:0] pix_s1;
	logic                valid_s1;

	logic [PIX_BITS-1:0] held_q;
	logic                held_vld_q;
	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] row_q;
	logic                run_q;
	logic [LEN_BITS-1:0] len_q;

	logic [PIX_BITS-1:0] hp;
	logic                hv;
	logic                run;
	logic [LEN_BITS-1:0] len;
	logic [DIM_BITS-1:0] col;
	logic [DIM_BITS-1:0] row;
	oplist_t             lst;
	logic                step;

	function automatic slot_t mk_byte(input logic [7:0] b);
		slot_t s;
		s.en   = 1'b1;
		s.kind = OP_BYTE;
		s.opn  = 1'b0;
		s.data = {{(PIX_BITS-8){1'b0}}, b};
		return s;
	endfunction

	function automatic slot_t mk_hdr(input logic [LEN_BITS-1:0] n);
		slot_t s;
		s.en   = 1'b1;
		s.kind = OP_HDR;
		s.opn  = 1'b0;
		s.data = {{(PIX_BITS-8){1'b0}}, 8'(n) - 8'd1};
		return s;
	endfunction

	function automatic slot_t mk_run(input logic [LEN_BITS-1:0] n);
		return mk_byte(RUN_FLAG + 8'(n) - 8'd1);
	endfunction

	// pixel bytes in output order, byte 0 lowest
	function automatic slot_t mk_pix(input logic [PIX_BITS-1:0] p, input depth_t m,
			input logic opn);
		slot_t       s;
		logic [15:0] v;
		v = ((p[15:0] & RGB_HI_MASK) >> 1) | (p[15:0] & RGB_LO_MASK);
		s.en   = 1'b1;
		s.kind = OP_PIXEL;
		s.opn  = opn;
		case (m)
			MODE_MONO:  s.data = {{(PIX_BITS-8){1'b0}}, ~p[7:0]};
			MODE_INDEX: s.data = {{(PIX_BITS-8){1'b0}}, p[7:0]};
			MODE_RGB16: s.data = {{(PIX_BITS-16){1'b0}}, v};
			default:    s.data = p;
		endcase
		return s;
	endfunction

	assign step       = valid_s1 && list_take;
	assign s_tready   = !valid_s1 || list_take;
	assign list_valid = valid_s1;
	assign list       = lst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cfg.clear) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_vld_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			run_q      <= 1'b0;
			len_q      <= '0;
		end else if (cfg.clear) begin
			held_q     <= '0;
			held_vld_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			run_q      <= 1'b0;
			len_q      <= '0;
		end else if (step) begin
			held_q     <= hp;
			held_vld_q <= hv;
			col_q      <= col;
			row_q      <= row;
			run_q      <= run;
			len_q      <= len;
		end
	end

	always_comb begin
		logic [PIX_BITS-1:0] p;
		logic [DIM_BITS:0]   elems;
		logic [DIM_BITS:0]   rows;
		logic [DIM_BITS:0]   row_inc;
		logic                last;

		case (cfg.depth_mode)
			MODE_RGB24: p = pix_s1;
			MODE_RGB16: p = {{(PIX_BITS-16){1'b0}}, pix_s1[15:0]};
			default:    p = {{(PIX_BITS-8){1'b0}}, pix_s1[7:0]};
		endcase

		// mono rows count bytes of eight pixels
		if (cfg.depth_mode == MODE_MONO) begin
			elems = ({1'b0, cfg.image_width} + (DIM_BITS+1)'(7)) >> 3;
		end else begin
			elems = {1'b0, cfg.image_width};
		end
		if (elems == '0) begin
			elems = (DIM_BITS+1)'(1);
		end
		rows = (cfg.image_rows == '0) ? (DIM_BITS+1)'(1) : {1'b0, cfg.image_rows};
		last = ({1'b0, col_q} + (DIM_BITS+1)'(1)) >= elems;

		lst = '0;
		hp  = held_q;
		hv  = held_vld_q;
		run = run_q;
		len = len_q;
		col = col_q;
		row = row_q;
		row_inc = '0;

		if (len != '0 && run) begin
			// open run: extend and close at full length, or close on a different pixel
			if (p == hp) begin
				len = len + LEN_BITS'(1);
				if (len >= LEN_BITS'(MAX_PACKET)) begin
					lst.slot[SL_M1] = mk_run(len);
					lst.slot[SL_M2] = mk_pix(hp, cfg.depth_mode, 1'b0);
					len = '0;
					run = 1'b0;
				end
			end else begin
				lst.slot[SL_M1] = mk_run(len);
				lst.slot[SL_M2] = mk_pix(hp, cfg.depth_mode, 1'b0);
				len = '0;
				run = 1'b0;
				hp  = p;
				hv  = 1'b1;
			end
		end else if (hv) begin
			if (p == hp) begin
				// pair found: close any raw packet and start a run
				if (len != '0) begin
					lst.slot[SL_M1] = mk_hdr(len);
				end
				run = 1'b1;
				len = LEN_BITS'(2);
				hv  = 1'b0;
				if (len >= LEN_BITS'(MAX_PACKET)) begin
					lst.slot[SL_M2] = mk_run(len);
					lst.slot[SL_M3] = mk_pix(hp, cfg.depth_mode, 1'b0);
					len = '0;
					run = 1'b0;
				end
			end else begin
				// held pixel goes raw
				if (len == '0) begin
					lst.slot[SL_M1] = mk_pix(hp, cfg.depth_mode, 1'b1);
					len = LEN_BITS'(1);
					run = 1'b0;
				end else begin
					lst.slot[SL_M1] = mk_pix(hp, cfg.depth_mode, 1'b0);
					len = len + LEN_BITS'(1);
				end
				if (len >= LEN_BITS'(MAX_PACKET)) begin
					lst.slot[SL_M2] = mk_hdr(len);
					len = '0;
				end
				hp = p;
			end
		end else begin
			hp = p;
			hv = 1'b1;
		end

		if (last) begin
			// end of row: flush whatever is pending
			if (hv) begin
				if (len != '0) begin
					lst.slot[SL_L1] = mk_pix(hp, cfg.depth_mode, 1'b0);
					len = len + LEN_BITS'(1);
				end else begin
					lst.slot[SL_L1] = mk_pix(hp, cfg.depth_mode, 1'b1);
					len = LEN_BITS'(1);
				end
				lst.slot[SL_L2] = mk_hdr(len);
				len = '0;
				hv  = 1'b0;
			end else if (len != '0 && run) begin
				lst.slot[SL_L1] = mk_run(len);
				lst.slot[SL_L2] = mk_pix(hp, cfg.depth_mode, 1'b0);
				len = '0;
				run = 1'b0;
			end
			if (cfg.depth_mode == MODE_MONO && elems[0]) begin
				lst.slot[SL_P1] = mk_byte(8'h00);
				lst.slot[SL_P2] = mk_byte(PAD_BYTE);
			end
			col = '0;
			row_inc = {1'b0, row_q} + (DIM_BITS+1)'(1);
			if (row_inc >= rows) begin
				lst.img_end = 1'b1;
				row = '0;
			end else begin
				row = row_inc[DIM_BITS-1:0];
			end
		end else begin
			col = col_q + DIM_BITS'(1);
		end
	end

	`TRLE_CHECK(a_len_below_max, len_q < LEN_BITS'(MAX_PACKET), "packet left open at full length")
	`TRLE_IMPLY(a_run_not_held, run_q && len_q != '0, !held_vld_q, "open run with a held pixel")
	`TRLE_IMPLY(a_ready_when_empty, !valid_s1, s_tready, "input blocked with empty stage")

endmodule

`default_nettype wire

[design/trle_ser.sv]
`timescale 1ns / 1ps
`default_nettype none

module trle_ser import trle_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 list_valid,
	input  wire oplist_t              list,
	output logic                      list_take,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [OFF_FIELD-1:0]      out_offset,
	output logic [7:0]                out_byte,
	output logic                      out_item_last,
	output logic                      out_image_end,
	output logic [OFF_FIELD-1:0]      out_length
);

	`include "tga_rle_pixel_encoder_assert.svh"

	oplist_t                list_s2;
	logic                   valid_s2;
	logic [SLOT_BITS-1:0]   slot_q;
	logic [1:0]             byte_q;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic [OFFSET_BITS-1:0] hdr_q;

	slot_t                  cur;
	logic [1:0]             nbytes;
	logic                   slot_last;
	logic                   has_next;
	logic [SLOT_BITS-1:0]   nxt;
	logic                   item_last;
	logic                   opening;
	logic [OFFSET_BITS-1:0] cnt_nxt;
	logic [OFFSET_BITS-1:0] hdr_nxt;
	logic [NSLOT-1:0]       above;
	logic [NSLOT-1:0]       in_en;
	logic                   fire;
	logic                   load;

	function automatic logic [SLOT_BITS-1:0] first_set(input logic [NSLOT-1:0] m);
		logic [SLOT_BITS-1:0] r;
		r = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = SLOT_BITS'(i);
			end
		end
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < NSLOT; i++) begin
			above[i] = list_s2.slot[i].en && (SLOT_BITS'(i) > slot_q);
			in_en[i] = list.slot[i].en;
		end
	end

	assign cur = list_s2.slot[slot_q];

	always_comb begin
		if (cur.kind == OP_PIXEL) begin
			case (cfg.depth_mode)
				MODE_RGB16: nbytes = 2'd2;
				MODE_RGB24: nbytes = 2'd3;
				default:    nbytes = 2'd1;
			endcase
		end else begin
			nbytes = 2'd1;
		end
	end

	assign slot_last = byte_q == (nbytes - 2'd1);
	assign has_next  = |above;
	assign nxt       = first_set(above);
	assign item_last = slot_last && !has_next;
	assign opening   = cur.kind == OP_PIXEL && cur.opn && byte_q == 2'd0;

	always_comb begin
		case (byte_q)
			2'd0:    out_byte = cur.data[7:0];
			2'd1:    out_byte = cur.data[15:8];
			default: out_byte = cur.data[23:16];
		endcase
	end

	// an opening pixel first reserves its packet header byte
	always_comb begin
		hdr_nxt = hdr_q;
		if (cur.kind == OP_HDR) begin
			out_offset = OFF_FIELD'(hdr_q);
			cnt_nxt    = cnt_q;
		end else if (opening) begin
			out_offset = OFF_FIELD'(cnt_q + OFFSET_BITS'(1));
			cnt_nxt    = cnt_q + OFFSET_BITS'(2);
			hdr_nxt    = cnt_q;
		end else begin
			out_offset = OFF_FIELD'(cnt_q);
			cnt_nxt    = cnt_q + OFFSET_BITS'(1);
		end
	end

	assign out_valid     = valid_s2;
	assign out_item_last = item_last;
	assign out_image_end = list_s2.img_end && item_last;
	assign out_length    = out_image_end ? OFF_FIELD'(cnt_nxt) : '0;

	assign fire      = valid_s2 && out_ready;
	assign list_take = !valid_s2 || (out_ready && item_last);
	assign load      = list_valid && list_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			slot_q   <= '0;
			byte_q   <= '0;
			cnt_q    <= '0;
			hdr_q    <= '0;
		end else if (cfg.clear) begin
			valid_s2 <= 1'b0;
			cnt_q    <= '0;
			hdr_q    <= '0;
		end else begin
			// an image end with no writes restarts the offset after the last byte
			if (load && !(|in_en) && list.img_end) begin
				cnt_q <= '0;
			end else if (fire) begin
				cnt_q <= out_image_end ? '0 : cnt_nxt;
			end
			if (fire) begin
				hdr_q <= hdr_nxt;
			end
			if (load) begin
				valid_s2 <= |in_en;
				slot_q   <= first_set(in_en);
				byte_q   <= '0;
			end else if (fire) begin
				if (slot_last) begin
					slot_q <= nxt;
					byte_q <= '0;
				end else begin
					byte_q <= byte_q + 2'd1;
				end
				if (item_last) begin
					valid_s2 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_s2 <= list;
		end
	end

	`TRLE_IMPLY(a_slot_enabled, valid_s2, list_s2.slot[slot_q].en, "walking a disabled slot")
	`TRLE_IMPLY(a_byte_in_range, valid_s2, byte_q < nbytes, "byte index past pixel size")
	`TRLE_NEXT(a_stall_holds, valid_s2 && !out_ready, $stable(slot_q) && $stable(byte_q), "moved on stall")
	`TRLE_NEXT(a_end_restarts, fire && out_image_end, cnt_q == '0, "offset not restarted after image")

endmodule

`default_nettype wire

[design/tga_rle_pixel_encoder.sv]
// TGA run-length pixel encoder. Pixel elements enter on the s_t* stream, one per item,
// row by row; the encoder writes the TGA run-length byte stream on the m_t* stream as
// one byte write per item (offset from the start of pixel data plus byte value).
// Runs of 2..128 equal pixels become run packets; other pixels go into raw packets whose
// header byte is written back at its reserved offset when the packet closes, so offsets
// are not always increasing. Packets never cross a row. depth_mode selects mono bytes
// (inverted, rows of an odd byte count padded with 00 FF), 8-bit index, RGB565 (written
// as little-endian 1-5-5-5) or 24-bit (byte order reversed). Rate: one pixel item
// enters per cycle while no item yields over one byte write and the output keeps up;
// each item yields 0 to 8 byte writes that leave at one per cycle while m_tready is
// high; the single byte-wide output serializer holds the input until an item's last
// write is taken. Input register, then op list register, precede the first byte write.
// Config writes restart the stream and must be made only while the block is idle;
// a write to index 3 restarts nothing. The last byte of each image has m_tlast set and
// carries the total encoded length; offsets restart at zero for the next image.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_encoder import trle_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// config write channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,	// 0 depth_mode, 1 image_width, 2 image_rows
	input  wire logic [DIM_BITS-1:0] cfg_data,

	// pixel input
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [PIX_BITS-1:0] s_tdata,	// [23:0] pixel_value

	// byte writes out
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [79:0]              m_tdata,	// [33:0] byte_offset, [41:34] byte_value,
	                                        	// [75:42] encoded_length, [79:76] zero
	output logic                     m_tuser,	// [0] last_of_item
	output logic                     m_tlast	// image_end
);

	cfg_t                cfg;
	oplist_t             list;
	logic                list_valid;
	logic                list_take;
	logic [OFF_FIELD-1:0] out_offset;
	logic [7:0]          out_byte;
	logic [OFF_FIELD-1:0] out_length;

	// register file, also flags the stream restart on a write to a known register
	trle_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register and packet decisions: one op list per pixel
	trle_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.list_valid (list_valid),
		.list       (list),
		.list_take  (list_take)
	);

	// op list register, byte walker and write/header offsets
	trle_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.list_valid    (list_valid),
		.list          (list),
		.list_take     (list_take),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_offset    (out_offset),
		.out_byte      (out_byte),
		.out_item_last (m_tuser),
		.out_image_end (m_tlast),
		.out_length    (out_length)
	);

	// pack fields lowest first, zero fill to whole bytes
	assign m_tdata = {4'b0000, out_length, out_byte, out_offset};

endmodule

`default_nettype wire

[tb/tga_rle_pixel_encoder_checker.sv]
`timescale 1ns / 1ps

module tga_rle_pixel_encoder_checker import trle_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [DIM_BITS-1:0] cfg_data,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [PIX_BITS-1:0] s_tdata,	// [23:0] pixel_value
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [79:0]         m_tdata,	// [33:0] offset, [41:34] byte, [75:42] length
	input  wire logic                m_tuser,	// [0] last_of_item
	input  wire logic                m_tlast,	// image_end
	output int                       error_count,
	output int                       writes_pending
);

	typedef struct {
		logic [OFF_FIELD-1:0] offset;
		logic [7:0]           value;
		logic                 item_last;
		logic                 image_last;
		logic [OFF_FIELD-1:0] total;
	} byte_write_t;

	byte_write_t writes_due[$];
	byte_write_t item_writes[$];
	byte_write_t due;
	int          errors;

	// register copies
	depth_t              mode;
	logic [DIM_BITS-1:0] width;
	logic [DIM_BITS-1:0] rows;

	// stream state
	logic [PIX_BITS-1:0]    held_pixel;
	logic                   held_valid;
	logic [DIM_BITS-1:0]    col;
	int                     row;
	logic                   is_run;
	int                     plen;
	logic [OFFSET_BITS-1:0] hdr_off;
	logic [OFFSET_BITS-1:0] wr_off;

	task automatic clear_stream();
		held_pixel = '0;
		held_valid = 1'b0;
		col        = '0;
		row        = 0;
		is_run     = 1'b0;
		plen       = 0;
		hdr_off    = '0;
		wr_off     = '0;
	endtask

	task automatic add_write(input logic [OFFSET_BITS-1:0] off, input logic [7:0] val);
		byte_write_t w;
		w.offset     = off;
		w.value      = val;
		w.item_last  = 1'b0;
		w.image_last = 1'b0;
		w.total      = '0;
		item_writes.push_back(w);
	endtask

	task automatic put_byte(input logic [7:0] val);
		add_write(wr_off, val);
		wr_off = wr_off + 1'b1;
	endtask

	task automatic put_formatted(input logic [PIX_BITS-1:0] p);
		logic [15:0] v;
		v = ((p[15:0] & RGB_HI_MASK) >> 1) | (p[15:0] & RGB_LO_MASK);
		case (mode)
			MODE_MONO:  put_byte(~p[7:0]);
			MODE_INDEX: put_byte(p[7:0]);
			MODE_RGB16: begin
				put_byte(v[7:0]);
				put_byte(v[15:8]);
			end
			default: begin
				put_byte(p[7:0]);
				put_byte(p[15:8]);
				put_byte(p[23:16]);
			end
		endcase
	endtask

	task automatic close_run_packet();
		put_byte(RUN_FLAG + 8'(plen - 1));
		put_formatted(held_pixel);
		plen   = 0;
		is_run = 1'b0;
	endtask

	task automatic close_raw_packet();
		add_write(hdr_off, 8'(plen - 1));
		plen = 0;
	endtask

	task automatic open_raw_packet(input logic [PIX_BITS-1:0] p);
		hdr_off = wr_off;
		wr_off  = wr_off + 1'b1;
		put_formatted(p);
		plen   = 1;
		is_run = 1'b0;
	endtask

	task automatic encode_pixel(input logic [PIX_BITS-1:0] raw);
		logic [PIX_BITS-1:0] p;
		int                  elems;
		int                  rows_eff;
		logic                last;
		case (mode)
			MODE_RGB24: p = raw;
			MODE_RGB16: p = {8'h00, raw[15:0]};
			default:    p = {16'h0000, raw[7:0]};
		endcase
		elems = (mode == MODE_MONO) ? (int'({16'h0, width}) + 7) / 8 : int'({16'h0, width});
		if (elems == 0)
			elems = 1;
		rows_eff = (rows == 0) ? 1 : int'({16'h0, rows});
		last = (int'({16'h0, col}) + 1 >= elems);
		item_writes.delete();

		if (plen > 0 && is_run) begin
			if (p == held_pixel) begin
				plen++;
				if (plen >= MAX_PACKET)
					close_run_packet();
			end else begin
				close_run_packet();
				held_pixel = p;
				held_valid = 1'b1;
			end
		end else if (held_valid) begin
			if (p == held_pixel) begin
				if (plen > 0)
					close_raw_packet();
				is_run     = 1'b1;
				plen       = 2;
				held_valid = 1'b0;
				if (plen >= MAX_PACKET)
					close_run_packet();
			end else begin
				if (plen == 0)
					open_raw_packet(held_pixel);
				else begin
					put_formatted(held_pixel);
					plen++;
				end
				if (plen >= MAX_PACKET)
					close_raw_packet();
				held_pixel = p;
			end
		end else begin
			held_pixel = p;
			held_valid = 1'b1;
		end

		if (last) begin
			if (held_valid) begin
				if (plen > 0) begin
					put_formatted(held_pixel);
					plen++;
				end else
					open_raw_packet(held_pixel);
				close_raw_packet();
				held_valid = 1'b0;
			end else if (plen > 0 && is_run)
				close_run_packet();
			if (mode == MODE_MONO && elems[0]) begin
				put_byte(8'h00);
				put_byte(PAD_BYTE);
			end
			col = '0;
			row++;
			if (row >= rows_eff) begin
				if (item_writes.size() > 0) begin
					item_writes[item_writes.size() - 1].image_last = 1'b1;
					item_writes[item_writes.size() - 1].total      = wr_off;
				end
				row    = 0;
				wr_off = '0;
			end
		end else
			col = col + 1'b1;

		if (item_writes.size() > 0)
			item_writes[item_writes.size() - 1].item_last = 1'b1;
		foreach (item_writes[i])
			writes_due.push_back(item_writes[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode  = MODE_INDEX;
			width = 16'd1;
			rows  = 16'd1;
			clear_stream();
			writes_due.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (writes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected byte write: offset %h value %h", $time,
						m_tdata[33:0], m_tdata[41:34]);
				end else begin
					due = writes_due.pop_front();
					if (m_tdata[33:0] !== due.offset || m_tdata[41:34] !== due.value ||
					    m_tdata[75:42] !== due.total || m_tuser !== due.item_last ||
					    m_tlast !== due.image_last) begin
						errors++;
						$display("%0t: byte write mismatch: expected off %h val %h last %b end %b len %h",
							$time, due.offset, due.value, due.item_last, due.image_last, due.total);
						$display("%0t:                      actual   off %h val %h last %b end %b len %h",
							$time, m_tdata[33:0], m_tdata[41:34], m_tuser, m_tlast, m_tdata[75:42]);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEPTH: begin
						mode = depth_t'(cfg_data[1:0]);
						clear_stream();
					end
					REG_WIDTH: begin
						width = cfg_data;
						clear_stream();
					end
					REG_ROWS: begin
						rows = cfg_data;
						clear_stream();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				encode_pixel(s_tdata);
		end
		error_count    <= errors;
		writes_pending <= writes_due.size();
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import trle_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int IDLE_LIMIT   = 1000;	// cycles with no item moving on any channel
	localparam int DRAIN_CYCLES = 16;	// well past the input and op list registers
	localparam int LONG_HOLD    = 300;	// receiver hold-off, enough to back up the input
	localparam int RANDOM_ITEMS = 80;

	// no register sits at this index, a write there must leave the stream alone
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [DIM_BITS-1:0] cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [PIX_BITS-1:0] s_tdata   = '0;	// [23:0] pixel_value
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [79:0]         m_tdata;	// [33:0] byte_offset, [41:34] byte_value,
	                             	// [75:42] encoded_length, [79:76] zero
	logic                m_tuser;	// [0] last_of_item
	logic                m_tlast;	// image_end

	int error_count;
	int writes_pending;

	// idling knobs, percent per cycle
	int gap_pct   = 0;
	int stall_pct = 0;

	// long hold-off request, picked up by the receiver process
	int   hold_len    = 0;
	logic hold_toggle = 1'b0;
	logic hold_seen   = 1'b0;
	int   hold_left   = 0;

	int idle_cycles = 0;
	int phase_no    = 0;
	int sent        = 0;

	// what the stimulus believes the block is set to
	depth_t              cur_mode   = MODE_INDEX;
	logic [DIM_BITS-1:0] cur_width  = 16'd1;
	logic [DIM_BITS-1:0] cur_rows   = 16'd1;
	logic [PIX_BITS-1:0] last_pixel = '0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	tga_rle_pixel_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	tga_rle_pixel_encoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.error_count    (error_count),
		.writes_pending (writes_pending)
	);

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= hold_len - 1;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles where nothing moves anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("** tga_rle_pixel_encoder: FAILED **");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// one pixel item, with random sender gaps ahead of it; ends on a falling edge
	task automatic send_pixel(input logic [PIX_BITS-1:0] v);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		last_pixel = v;
		sent++;
	endtask

	// valid stays high across back-to-back writes, the caller drops it
	task automatic cfg_write(input logic [1:0] idx, input logic [DIM_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// sender stops until every byte write is out and the pipeline has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (writes_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// new setting, and the next idling phase with it
	task automatic configure(input depth_t m, input logic [DIM_BITS-1:0] w,
	                         input logic [DIM_BITS-1:0] h);
		settle();
		// only the low two bits select the depth, the rest is noise
		cfg_write(REG_DEPTH, {14'($urandom), m});
		cfg_write(REG_WIDTH, w);
		cfg_write(REG_ROWS, h);
		cfg_valid <= 1'b0;
		cur_mode  = m;
		cur_width = w;
		cur_rows  = h;
		case (phase_no % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 57; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 57; end
			default: begin gap_pct = 7; stall_pct = 7; end
		endcase
		phase_no++;
	endtask

	// equal or unequal to the previous pixel in the bits the depth compares,
	// the unused upper bits always random
	function automatic logic [PIX_BITS-1:0] next_pixel(input logic same);
		logic [PIX_BITS-1:0] mask;
		logic [PIX_BITS-1:0] p;
		mask = (cur_mode == MODE_RGB24) ? 24'hffffff :
		       (cur_mode == MODE_RGB16) ? 24'h00ffff : 24'h0000ff;
		p = 24'($urandom);
		if (same)
			p = (p & ~mask) | (last_pixel & mask);
		else if (((p ^ last_pixel) & mask) == 0)
			p[0] = ~p[0];
		return p;
	endfunction

	// elements in a whole image at the current setting, zero counts as one
	function automatic int image_items();
		int elems;
		int nrows;
		elems = (cur_mode == MODE_MONO) ? (int'({16'h0, cur_width}) + 7) / 8
		                                : int'({16'h0, cur_width});
		if (elems == 0)
			elems = 1;
		nrows = (cur_rows == 0) ? 1 : int'({16'h0, cur_rows});
		return elems * nrows;
	endfunction

	// pause_at < 0 means no pause inside the image
	task automatic send_image(input int n, input int repeat_pct, input int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				settle();
			send_pixel(next_pixel($urandom_range(99) < repeat_pct));
		end
	endtask

	initial begin
		int             rand_start;
		int             img;
		int             n;
		depth_t         m;
		logic [15:0]    w;
		logic [15:0]    h;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// reset setting: index mode, 1x1 image, every pixel is a one-pixel raw image
		send_pixel(24'hffff00);
		send_pixel(24'h0000ff);

		// run of two (upper bits differ but are ignored), raw, run, last pixel alone
		configure(MODE_INDEX, 16'd6, 16'd1);
		send_pixel(24'h0000aa);
		send_pixel(24'hff00aa);
		send_pixel(24'h00003c);
		send_pixel(24'h00005a);
		send_pixel(24'h12345a);
		send_pixel(24'h0000ff);

		// mono, 17 pixels wide is three elements, odd so every row gets the pad
		configure(MODE_MONO, 16'd17, 16'd2);
		send_pixel(24'h000000);
		send_pixel(24'h000000);
		send_pixel(24'h0000ff);
		send_pixel(24'h0000ff);
		send_pixel(24'h000012);
		send_pixel(24'h0000ff);

		// zero width and zero rows count as one
		configure(MODE_RGB16, 16'd0, 16'd0);
		send_pixel(24'hffffff);

		// 565 to 1555 repacking, three different pixels in one raw packet at row end
		configure(MODE_RGB16, 16'd3, 16'd1);
		send_pixel(24'h00ffff);
		send_pixel(24'hab7fff);
		send_pixel(24'h0007e0);

		// 24-bit byte reversal, extremes
		configure(MODE_RGB24, 16'd4, 16'd1);
		send_pixel(24'hffffff);
		send_pixel(24'h000000);
		send_pixel(24'h000000);
		send_pixel(24'h123456);

		// write to the unused index mid-image, the image carries on
		configure(MODE_RGB24, 16'd4, 16'd2);
		send_pixel(24'h000001);
		send_pixel(24'habcdef);
		settle();
		cfg_write(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_pixel(24'habcdef);
		send_pixel(24'habcdef);

		// ---- largest registers, partial rows only ----
		configure(MODE_MONO, 16'hffff, 16'hffff);
		send_image(8, 40, -1);
		configure(MODE_INDEX, 16'hffff, 16'd1);
		send_image(4, 40, -1);

		// ---- random images ----
		rand_start = sent;
		img        = 0;
		while (sent - rand_start < RANDOM_ITEMS) begin
			m = depth_t'($urandom_range(3));
			if (m == MODE_MONO)
				w = 16'($urandom_range(40));
			else
				w = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(10, 1));
			h = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(3, 1));
			if (img == 2) begin
				// long enough to back the block up during the hold-off
				w = 16'd10;
				h = 16'd3;
			end
			configure(m, w, h);
			n = image_items();
			// now and then the image is cut short by the next setting
			if (img != 2 && $urandom_range(99) < 15)
				n = $urandom_range(n);
			if (img == 2) begin
				hold_len    = LONG_HOLD;
				hold_toggle = ~hold_toggle;
			end
			send_image(n, $urandom_range(70, 20), (img == 4) ? n / 2 : -1);
			img++;
		end

		// ---- wind down and verdict ----
		settle();
		if (error_count == 0)
			$display("** tga_rle_pixel_encoder: PASSED **");
		else
			$display("** tga_rle_pixel_encoder: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/trle_pkg.sv
design/trle_cfg.sv
design/trle_core.sv
design/trle_ser.sv
design/tga_rle_pixel_encoder.sv
tb/tga_rle_pixel_encoder_checker.sv
tb/tb.sv
